>>> src/mlfq_pkg.sv
package mlfq_pkg;

	localparam int NUM_LEVELS = 10;
	localparam int MAX_PROCS  = 16;

	// Slot and level widths. Queue positions wrap by truncation, so MAX_PROCS
	// stays a power of two.
	localparam int PID_W  = $clog2(MAX_PROCS);
	localparam int LVL_W  = $clog2(NUM_LEVELS);
	localparam int FILL_W = PID_W + 1;
	localparam int QA_W   = $clog2(NUM_LEVELS * MAX_PROCS);

	// Fixed field widths of the channels.
	localparam int SVC_W  = 16;
	localparam int OLVL_W = 4;
	localparam int CNT_W  = 5;

	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP1,
		S_PUSH,
		S_POP2,
		S_POP2W,
		S_RUN,
		S_OUT
	} sched_state_t;

endpackage

>>> src/mlfq_if.sv
interface mlfq_item_if import mlfq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [PID_W-1:0] process_id;
	logic [SVC_W-1:0] svc_ticks;

	modport source (output valid, kind, process_id, svc_ticks, input ready);
	modport sink (input valid, kind, process_id, svc_ticks, output ready);
endinterface

interface mlfq_result_if import mlfq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ran_valid;
	logic [PID_W-1:0]  ran_id;
	logic [OLVL_W-1:0] ran_level;
	logic              finished;
	logic              all_done;

	modport source (output valid, ran_valid, ran_id, ran_level, finished, all_done,
		input ready);
	modport sink (input valid, ran_valid, ran_id, ran_level, finished, all_done,
		output ready);
endinterface

>>> src/mlfq_ram.sv
module mlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/multilevel_feedback_scheduler.sv
// Arrival beats with nonzero service write both memories in the accept cycle
// unless level 0 is full. A tick beat reads the queue memory once per pop and
// writes it for the demotion; when a process runs, a read-modify-write of the
// service-time memory for it precedes the registered result.
// Reset clears the queue pointers, the running state and the completion count;
// the memory contents are not cleared and no clearing pass runs.
module multilevel_feedback_scheduler import mlfq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	mlfq_item_if.sink        item,
	mlfq_result_if.source    result
);

	sched_state_t state_q, state_d;

	logic [PID_W-1:0]  head_q [NUM_LEVELS];
	logic [FILL_W-1:0] fill_q [NUM_LEVELS];
	logic              rv_q, qu_q, got_q;
	logic [PID_W-1:0]  rs_q;
	logic [LVL_W-1:0]  rl_q, pop_lvl_q;
	logic [CNT_W-1:0]  done_q, pc_q;

	logic              out_valid_q, o_ran_q, o_fin_q, o_all_q;
	logic [PID_W-1:0]  o_id_q;
	logic [OLVL_W-1:0] o_lvl_q;

	// Memory ports.
	logic              qm_we, qm_re, rm_we, rm_re;
	logic [QA_W-1:0]   qm_waddr, qm_raddr;
	logic [PID_W-1:0]  qm_wdata, qm_rdata, rm_waddr, rm_raddr;
	logic [SVC_W-1:0]  rm_wdata, rm_rdata;

	// Control strobes from the sequencer.
	logic              pop_en, push_en, arr_push, set_run, clr_run, run_upd, got_ld;
	logic              out_load, ld_ran, ld_fin, ld_all;

	logic              top_any;
	logic [LVL_W-1:0]  top_lvl, down_lvl;
	logic              out_free, accept, all_done_now, fin_now;
	logic [CNT_W-1:0]  done_next;

	function automatic logic [QA_W-1:0] qaddr(logic [LVL_W-1:0] lvl, logic [PID_W-1:0] pos);
		qaddr = QA_W'(lvl) * QA_W'(MAX_PROCS) + QA_W'(pos);
	endfunction

	mlfq_ram #(.WIDTH(PID_W), .DEPTH(NUM_LEVELS * MAX_PROCS)) u_queue_ram (
		.clk   (clk),
		.we    (qm_we),
		.waddr (qm_waddr),
		.wdata (qm_wdata),
		.re    (qm_re),
		.raddr (qm_raddr),
		.rdata (qm_rdata)
	);

	mlfq_ram #(.WIDTH(SVC_W), .DEPTH(MAX_PROCS)) u_remain_ram (
		.clk   (clk),
		.we    (rm_we),
		.waddr (rm_waddr),
		.wdata (rm_wdata),
		.re    (rm_re),
		.raddr (rm_raddr),
		.rdata (rm_rdata)
	);

	// Highest priority non-empty level.
	always_comb begin
		top_any = 1'b0;
		top_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				top_any = 1'b1;
				top_lvl = LVL_W'(i);
			end
		end
	end

	assign down_lvl = (rl_q == LVL_W'(NUM_LEVELS - 1)) ? rl_q : rl_q + 1'b1;

	assign accept       = item.valid && item.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign all_done_now = done_q >= pc_q;
	assign fin_now      = rm_rdata == SVC_W'(1);
	assign done_next    = (fin_now && done_q != '1) ? done_q + 1'b1 : done_q;

	always_comb begin
		state_d  = state_q;
		qm_we    = 1'b0;
		qm_waddr = '0;
		qm_wdata = '0;
		qm_re    = 1'b0;
		qm_raddr = '0;
		rm_we    = 1'b0;
		rm_waddr = '0;
		rm_wdata = '0;
		rm_re    = 1'b0;
		rm_raddr = '0;
		pop_en   = 1'b0;
		push_en  = 1'b0;
		arr_push = 1'b0;
		set_run  = 1'b0;
		clr_run  = 1'b0;
		run_upd  = 1'b0;
		got_ld   = 1'b0;
		out_load = 1'b0;
		ld_ran   = 1'b0;
		ld_fin   = 1'b0;
		ld_all   = all_done_now;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.kind == KIND_ARRIVAL) begin
						if (item.svc_ticks != '0 &&
								fill_q[0] != FILL_W'(MAX_PROCS)) begin
							arr_push = 1'b1;
							rm_we    = 1'b1;
							rm_waddr = item.process_id;
							rm_wdata = item.svc_ticks;
							qm_we    = 1'b1;
							qm_waddr = qaddr('0, head_q[0] + fill_q[0][PID_W-1:0]);
							qm_wdata = item.process_id;
						end
					end else if (all_done_now) begin
						state_d = S_OUT;
					end else if (rv_q && qu_q) begin
						state_d = S_POP1;
					end else if (!rv_q) begin
						state_d = S_POP2;
					end else begin
						rm_re    = 1'b1;
						rm_raddr = rs_q;
						state_d  = S_RUN;
					end
				end
			end
			S_POP1: begin
				pop_en   = top_any;
				qm_re    = top_any;
				qm_raddr = qaddr(top_lvl, head_q[top_lvl]);
				got_ld   = 1'b1;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				// A running process always has service left, so it is demoted, or requeued on
				// the lowest level, unless the target level is full.
				push_en  = fill_q[down_lvl] != FILL_W'(MAX_PROCS);
				qm_we    = push_en;
				qm_waddr = qaddr(down_lvl, head_q[down_lvl] + fill_q[down_lvl][PID_W-1:0]);
				qm_wdata = rs_q;
				if (got_q) begin
					set_run  = 1'b1;
					rm_re    = 1'b1;
					rm_raddr = qm_rdata;
					state_d  = S_RUN;
				end else begin
					clr_run = 1'b1;
					state_d = S_POP2;
				end
			end
			S_POP2: begin
				if (top_any) begin
					pop_en   = 1'b1;
					qm_re    = 1'b1;
					qm_raddr = qaddr(top_lvl, head_q[top_lvl]);
					state_d  = S_POP2W;
				end else begin
					state_d = S_OUT;
				end
			end
			S_POP2W: begin
				set_run  = 1'b1;
				rm_re    = 1'b1;
				rm_raddr = qm_rdata;
				state_d  = S_RUN;
			end
			S_RUN: begin
				if (out_free) begin
					run_upd  = 1'b1;
					rm_we    = rm_rdata != '0;
					rm_waddr = rs_q;
					rm_wdata = rm_rdata - 1'b1;
					out_load = 1'b1;
					ld_ran   = 1'b1;
					ld_fin   = fin_now;
					ld_all   = done_next >= pc_q;
					state_d  = S_IDLE;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
			rv_q        <= 1'b0;
			qu_q        <= 1'b0;
			got_q       <= 1'b0;
			rs_q        <= '0;
			rl_q        <= '0;
			pop_lvl_q   <= '0;
			done_q      <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_data;
			end
			if (pop_en) begin
				head_q[top_lvl] <= head_q[top_lvl] + 1'b1;
				fill_q[top_lvl] <= fill_q[top_lvl] - 1'b1;
				pop_lvl_q       <= top_lvl;
			end
			if (push_en) begin
				fill_q[down_lvl] <= fill_q[down_lvl] + 1'b1;
			end
			if (arr_push) begin
				fill_q[0] <= fill_q[0] + 1'b1;
			end
			if (got_ld) begin
				got_q <= top_any;
			end
			if (set_run) begin
				rv_q <= 1'b1;
				qu_q <= 1'b0;
				rs_q <= qm_rdata;
				rl_q <= pop_lvl_q;
			end
			if (clr_run) begin
				rv_q <= 1'b0;
				qu_q <= 1'b0;
			end
			if (run_upd) begin
				done_q <= done_next;
				if (rm_rdata <= SVC_W'(1)) begin
					rv_q <= 1'b0;
					qu_q <= 1'b0;
				end else begin
					qu_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; only a loaded beat is ever presented.
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_ran_q <= ld_ran;
			o_id_q  <= ld_ran ? rs_q : '0;
			o_lvl_q <= ld_ran ? OLVL_W'(rl_q) : '0;
			o_fin_q <= ld_fin;
			o_all_q <= ld_all;
		end
	end

	assign item.ready       = state_q == S_IDLE;
	assign result.valid     = out_valid_q;
	assign result.ran_valid = o_ran_q;
	assign result.ran_id    = o_id_q;
	assign result.ran_level = o_lvl_q;
	assign result.finished  = o_fin_q;
	assign result.all_done  = o_all_q;

endmodule
